[sv/lpmb_pkg.sv]
// ----------------------------------------------------------------------------
// lpmb_pkg: shared types and constants of the message batcher
// Payload structs of the input and result channels, opcodes, result kinds
// and the width constants fixed by the batch format.
// ----------------------------------------------------------------------------
package lpmb_pkg;

  // batch format
  localparam int unsigned PREFIX_BYTES  = 4;
  localparam int unsigned LEN_W         = 16;
  localparam int unsigned BYTE_W        = 8;
  localparam int unsigned MSGS_W        = 14;
  localparam int unsigned LIMIT_RESET   = 1400;
  localparam logic [BYTE_W-1:0] BYTE_MASK = 8'hFF;

  // input opcodes
  localparam logic OP_DATA  = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  // result kinds
  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_CLOSE = 2'd1;
  localparam logic [1:0] KIND_DROP  = 2'd2;

  // one input transaction
  typedef struct packed {
    logic              opcode;
    logic [BYTE_W-1:0] data_byte;
    logic [LEN_W-1:0]  msg_len;
  } in_item_t;

  // one result transaction
  typedef struct packed {
    logic [1:0]        kind;
    logic [BYTE_W-1:0] out_byte;
    logic [MSGS_W-1:0] batch_msgs;
    logic [LEN_W-1:0]  batch_bytes;
    logic              last;
  } out_item_t;

endpackage

[sv/lpmb_in_if.sv]
// ----------------------------------------------------------------------------
// lpmb_in_if: message byte / flush channel
// Valid/ready channel carrying one input transaction of the batcher.
// ----------------------------------------------------------------------------
interface lpmb_in_if;
  import lpmb_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

[sv/lpmb_out_if.sv]
// ----------------------------------------------------------------------------
// lpmb_out_if: batch stream result channel
// Valid/ready channel carrying one result transaction of the batcher.
// ----------------------------------------------------------------------------
interface lpmb_out_if;
  import lpmb_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

[sv/length_prefixed_message_batcher_core.sv]
// ----------------------------------------------------------------------------
// length_prefixed_message_batcher_core: packs message bytes into batches
// Takes one message byte or flush per transaction and emits the batch stream
// (length prefix, reserved bytes, data), batch-close and drop reports.
// ----------------------------------------------------------------------------
// A continuation byte's single result (none while dropping) is presented the
// next cycle; the next byte can be taken with it. A message's first byte
// yields five results (two length bytes, two reserved zeros, the data byte),
// or a drop report if it exceeds the limit, plus a close report if it closes
// the open batch. Results leave one per cycle while batch_out is ready; input
// waits until an item's last result (up to six) is taken. A flush yields at
// most one close report. The user must write batch_limit (reset value 1400)
// through cfg_wr_en/cfg_wr_data while idle; the block does not enforce it.
module length_prefixed_message_batcher_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [lpmb_pkg::LEN_W-1:0]  cfg_wr_data,
  lpmb_in_if.sink                     msg_in,
  lpmb_out_if.source                  batch_out
);
  import lpmb_pkg::*;

  // what follows the optional close report of an item
  typedef enum logic [3:0] {
    BODY_NONE = 4'b0001,
    BODY_DROP = 4'b0010,
    BODY_DATA = 4'b0100,
    BODY_MSG  = 4'b1000
  } body_t;

  // batch state
  logic [LEN_W-1:0]  batch_limit;
  logic [LEN_W-1:0]  bytes_used, bytes_used_next;
  logic [MSGS_W-1:0] msg_count, msg_count_next;
  logic [LEN_W-1:0]  bytes_left, bytes_left_next;
  logic              dropping, dropping_next;

  // result register of the item being delivered
  logic              pend_valid;
  logic [2:0]        pos;
  logic              pend_close;
  body_t             pend_body;
  logic [MSGS_W-1:0] pend_msgs;
  logic [LEN_W-1:0]  pend_bytes;
  logic [LEN_W-1:0]  pend_len;
  logic [BYTE_W-1:0] pend_data;

  // decode of the incoming item
  logic              close_now;
  body_t             body_now;
  logic [LEN_W-1:0]  len_eff;
  logic [LEN_W:0]    need;
  logic [LEN_W+1:0]  fill;
  logic              accept, take, done;
  logic [2:0]        n_results, body_pos;
  out_item_t         res;

  // state update for an accepted transaction
  always_comb begin
    bytes_used_next = bytes_used;
    msg_count_next  = msg_count;
    bytes_left_next = bytes_left;
    dropping_next   = dropping;
    close_now       = 1'b0;
    body_now        = BODY_NONE;
    len_eff         = (msg_in.payload.msg_len == '0) ? LEN_W'(1) : msg_in.payload.msg_len;
    need            = (LEN_W+1)'(PREFIX_BYTES) + {1'b0, len_eff};
    fill            = {2'b00, bytes_used} + {1'b0, need};
    if (msg_in.payload.opcode == OP_FLUSH) begin
      if (bytes_left == '0 && msg_count != '0) begin
        close_now       = 1'b1;
        bytes_used_next = '0;
        msg_count_next  = '0;
      end
    end else if (bytes_left != '0) begin
      if (!dropping) begin
        body_now = BODY_DATA;
      end
      bytes_left_next = bytes_left - LEN_W'(1);
      if (bytes_left_next == '0) begin
        dropping_next = 1'b0;
      end
    end else begin
      // message start
      if (fill > {2'b00, batch_limit} && msg_count != '0) begin
        close_now       = 1'b1;
        bytes_used_next = '0;
        msg_count_next  = '0;
      end
      bytes_left_next = len_eff - LEN_W'(1);
      if (need > {1'b0, batch_limit}) begin
        body_now      = BODY_DROP;
        dropping_next = (bytes_left_next != '0);
      end else begin
        body_now        = BODY_MSG;
        bytes_used_next = bytes_used_next + need[LEN_W-1:0];
        msg_count_next  = msg_count_next + MSGS_W'(1);
        dropping_next   = 1'b0;
      end
    end
  end

  // result sequencing
  always_comb begin
    case (pend_body)
      BODY_NONE: n_results = {2'b00, pend_close};
      BODY_DROP: n_results = 3'd1 + {2'b00, pend_close};
      BODY_DATA: n_results = 3'd1 + {2'b00, pend_close};
      BODY_MSG:  n_results = 3'd5 + {2'b00, pend_close};
      default:   n_results = {2'b00, pend_close};
    endcase
    body_pos = pos - {2'b00, pend_close};
  end

  // result payload selection
  always_comb begin
    res = '0;
    if (pend_close && pos == '0) begin
      res.kind        = KIND_CLOSE;
      res.batch_msgs  = pend_msgs;
      res.batch_bytes = pend_bytes;
    end else begin
      case (pend_body)
        BODY_DROP: res.kind = KIND_DROP;
        BODY_DATA: begin
          res.kind     = KIND_BYTE;
          res.out_byte = pend_data;
        end
        BODY_MSG: begin
          res.kind = KIND_BYTE;
          case (body_pos)
            3'd0:    res.out_byte = pend_len[LEN_W-1:BYTE_W] & BYTE_MASK;
            3'd1:    res.out_byte = pend_len[BYTE_W-1:0] & BYTE_MASK;
            3'd2:    res.out_byte = '0;
            3'd3:    res.out_byte = '0;
            default: res.out_byte = pend_data;
          endcase
        end
        default: res.kind = KIND_BYTE;
      endcase
    end
    res.last = (pos == n_results - 3'd1);
  end

  // handshakes
  assign batch_out.valid   = pend_valid;
  assign batch_out.payload = res;
  assign take              = pend_valid && batch_out.ready;
  assign done              = take && res.last;
  assign msg_in.ready      = !pend_valid || done;
  assign accept            = msg_in.valid && msg_in.ready;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      batch_limit <= LEN_W'(LIMIT_RESET);
    end else if (cfg_wr_en) begin
      batch_limit <= cfg_wr_data;
    end
  end

  // batch state and result control
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_used <= '0;
      msg_count  <= '0;
      bytes_left <= '0;
      dropping   <= 1'b0;
      pend_valid <= 1'b0;
      pos        <= '0;
    end else begin
      if (accept) begin
        bytes_used <= bytes_used_next;
        msg_count  <= msg_count_next;
        bytes_left <= bytes_left_next;
        dropping   <= dropping_next;
        pend_valid <= close_now || (body_now != BODY_NONE);
        pos        <= '0;
      end else if (done) begin
        pend_valid <= 1'b0;
      end else if (take) begin
        pos <= pos + 3'd1;
      end
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (accept) begin
      pend_close <= close_now;
      pend_body  <= body_now;
      pend_msgs  <= msg_count;
      pend_bytes <= bytes_used;
      pend_len   <= len_eff;
      pend_data  <= msg_in.payload.data_byte;
    end
  end

endmodule
